// ===== hw/rtl/foreground_bounding_box_assert.svh =====
// ----------------------------------------------------------------------------
// Foreground bounding box assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOREGROUND_BOUNDING_BOX_ASSERT_SVH
`define FOREGROUND_BOUNDING_BOX_ASSERT_SVH

`ifndef SYNTHESIS

`define FBB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbb: same-cycle check failed");

`define FBB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbb: next-cycle check failed");

`else

`define FBB_ASSERT_IMPL(lbl, ante, cons)

`define FBB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/fbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box package
// Payload types, configuration layout and classification thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

package fbb_pkg;

    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 12;
    localparam int WIDTH_REG_W = 13;
    localparam int REG_IDX_W   = 2;
    localparam int SUM_W       = 10;

    localparam logic [REG_IDX_W-1:0] REG_BG_RED      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BG_GREEN    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BG_BLUE     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd3;

    localparam logic [COLOR_W-1:0]     RST_BG_RED      = 8'd106;
    localparam logic [COLOR_W-1:0]     RST_BG_GREEN    = 8'd76;
    localparam logic [COLOR_W-1:0]     RST_BG_BLUE     = 8'd219;
    localparam logic [WIDTH_REG_W-1:0] RST_IMAGE_WIDTH = 13'd4096;

    localparam logic [COLOR_W-1:0] ALPHA_MIN   = 8'd32;
    localparam logic [SUM_W-1:0]   DIFF_MIN    = 10'd56;
    localparam int                 LUM_BRIGHT  = 180;
    localparam int                 LUM_DIM     = 60;
    localparam logic [SUM_W-1:0]   SUM_BRIGHT  = SUM_W'(3 * (LUM_BRIGHT + 1));
    localparam logic [SUM_W-1:0]   SUM_DIM     = SUM_W'(3 * (LUM_DIM + 1));
    localparam logic [COLOR_W-1:0] RED_WARM    = 8'd120;
    localparam logic [COLOR_W-1:0] GREEN_WARM  = 8'd90;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        logic               end_of_frame;
    } pixel_t;

    typedef struct packed {
        logic   found;
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
    } box_t;

    typedef struct packed {
        logic [COLOR_W-1:0]     bg_red;
        logic [COLOR_W-1:0]     bg_green;
        logic [COLOR_W-1:0]     bg_blue;
        logic [WIDTH_REG_W-1:0] image_width;
    } cfg_t;

    typedef struct packed {
        logic fg;
        logic eof;
    } pix_tag_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fbb_queue.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box request queue
// Small register FIFO between the classifier and the box tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = 2,
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW  = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbb_front.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box front end
// Accepts pixels, classifies them and tags each with its column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_front #(
    parameter int MAX_DIM = 4096,
    localparam int CW     = $clog2(MAX_DIM),
    localparam int WW     = ((CW > fbb_pkg::WIDTH_REG_W) ? CW : fbb_pkg::WIDTH_REG_W) + 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire fbb_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire fbb_pkg::pixel_t in_data,
    input  wire logic            full,
    output logic                 push,
    output fbb_pkg::pix_tag_t    push_tag,
    output logic [CW-1:0]        push_col,
    output logic [CW-1:0]        push_row
);

    logic [CW-1:0]                  col_reg, col_next;
    logic [CW-1:0]                  row_reg, row_next;
    logic [fbb_pkg::COLOR_W-1:0]    diff_r, diff_g, diff_b;
    logic [fbb_pkg::SUM_W-1:0]      diff_sum;
    logic [fbb_pkg::SUM_W-1:0]      color_sum;
    logic                           is_bg;
    logic                           is_fg;
    logic [WW-1:0]                  width_ext;
    logic [WW-1:0]                  width_m1;
    logic                           wrap;

    function automatic logic [fbb_pkg::COLOR_W-1:0] abs_diff(
        input logic [fbb_pkg::COLOR_W-1:0] a,
        input logic [fbb_pkg::COLOR_W-1:0] b
    );
        return (a >= b) ? a - b : b - a;
    endfunction

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        diff_r    = abs_diff(in_data.red,   cfg.bg_red);
        diff_g    = abs_diff(in_data.green, cfg.bg_green);
        diff_b    = abs_diff(in_data.blue,  cfg.bg_blue);
        diff_sum  = fbb_pkg::SUM_W'(diff_r) + fbb_pkg::SUM_W'(diff_g)
                  + fbb_pkg::SUM_W'(diff_b);
        color_sum = fbb_pkg::SUM_W'(in_data.red) + fbb_pkg::SUM_W'(in_data.green)
                  + fbb_pkg::SUM_W'(in_data.blue);
        is_bg     = (in_data.alpha < fbb_pkg::ALPHA_MIN) || (diff_sum < fbb_pkg::DIFF_MIN);
        is_fg     = !is_bg
                  && ((color_sum >= fbb_pkg::SUM_BRIGHT)
                      || ((in_data.red > fbb_pkg::RED_WARM)
                          && (in_data.green > fbb_pkg::GREEN_WARM))
                      || (color_sum >= fbb_pkg::SUM_DIM));
    end

    // clamp out-of-range widths to the maximum
    always_comb
    begin
        width_ext = WW'(cfg.image_width);
        if ((width_ext == '0) || (width_ext > WW'(MAX_DIM)))
        begin
            width_m1 = WW'(MAX_DIM - 1);
        end
        else
        begin
            width_m1 = width_ext - WW'(1);
        end
        wrap = (WW'(col_reg) >= width_m1);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (in_data.end_of_frame)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                if (row_reg < CW'(MAX_DIM - 1))
                begin
                    row_next = row_reg + CW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    assign push_tag.fg  = is_fg;
    assign push_tag.eof = in_data.end_of_frame;
    assign push_col     = col_reg;
    assign push_row     = row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fbb_back.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box back end
// Folds tagged requests into the box and emits it on the frame's last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module fbb_back #(
    parameter int MAX_DIM = 4096,
    localparam int CW     = $clog2(MAX_DIM)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire fbb_pkg::pix_tag_t req_tag,
    input  wire logic [CW-1:0]     req_col,
    input  wire logic [CW-1:0]     req_row,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fbb_pkg::box_t          out_data
);

    logic          any_reg, any_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] top_reg, top_next;
    logic [CW-1:0] right_reg, right_next;
    logic [CW-1:0] bottom_reg, bottom_next;
    logic          any_upd;
    logic [CW-1:0] left_upd, top_upd, right_upd, bottom_upd;
    logic          out_valid_reg, out_valid_next;
    fbb_pkg::box_t out_reg, out_next;

    // hold an end-of-frame request while a finished box still waits
    assign pop = req_valid && !(req_tag.eof && out_valid_reg && out_stall);

    always_comb
    begin
        any_upd    = any_reg;
        left_upd   = left_reg;
        top_upd    = top_reg;
        right_upd  = right_reg;
        bottom_upd = bottom_reg;
        if (req_tag.fg)
        begin
            any_upd = 1'b1;
            if (!any_reg)
            begin
                left_upd   = req_col;
                right_upd  = req_col;
                top_upd    = req_row;
                bottom_upd = req_row;
            end
            else
            begin
                if (req_col < left_reg)
                begin
                    left_upd = req_col;
                end
                if (req_col > right_reg)
                begin
                    right_upd = req_col;
                end
                if (req_row < top_reg)
                begin
                    top_upd = req_row;
                end
                if (req_row > bottom_reg)
                begin
                    bottom_upd = req_row;
                end
            end
        end
    end

    always_comb
    begin
        any_next       = any_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        right_next     = right_reg;
        bottom_next    = bottom_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            if (req_tag.eof)
            begin
                out_next.found  = any_upd;
                out_next.left   = fbb_pkg::coord_t'(left_upd);
                out_next.top    = fbb_pkg::coord_t'(top_upd);
                out_next.right  = fbb_pkg::coord_t'(right_upd);
                out_next.bottom = fbb_pkg::coord_t'(bottom_upd);
                out_valid_next  = 1'b1;
                any_next        = 1'b0;
                left_next       = '0;
                top_next        = '0;
                right_next      = '0;
                bottom_next     = '0;
            end
            else
            begin
                any_next    = any_upd;
                left_next   = left_upd;
                top_next    = top_upd;
                right_next  = right_upd;
                bottom_next = bottom_upd;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg       <= 1'b0;
            left_reg      <= '0;
            top_reg       <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            any_reg       <= any_next;
            left_reg      <= left_next;
            top_reg       <= top_next;
            right_reg     <= right_next;
            bottom_reg    <= bottom_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/foreground_bounding_box.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box
// Finds the box around the foreground pixels of a raster-order RGBA frame.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock when out_stall stays low. The
// front end classifies each pixel against the background color in the same
// cycle it is accepted and tags it with its column and row; a two-entry
// request queue hands it to the back end, which folds it into the box. The
// pixel flagged end_of_frame, once popped, loads its box into the output
// register, and the next frame starts clean on the following pixel.
// in_stall rises only when the queue is full, which happens when a finished
// box waits on out_stall and a further end-of-frame pixel reaches the back
// end. Write configuration only while no frame is in flight.
`default_nettype none

`include "foreground_bounding_box_assert.svh"

module foreground_bounding_box #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [fbb_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [fbb_pkg::WIDTH_REG_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire fbb_pkg::pixel_t                   in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output fbb_pkg::box_t                          out_data
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int DATA_W = 2 + 2 * CW;

    fbb_pkg::cfg_t     cfg_reg, cfg_next;
    logic              full;
    logic              empty;
    logic              push;
    fbb_pkg::pix_tag_t push_tag;
    logic [CW-1:0]     push_col;
    logic [CW-1:0]     push_row;
    logic              pop;
    logic [DATA_W-1:0] pop_data;
    fbb_pkg::pix_tag_t pop_tag;
    logic [CW-1:0]     pop_col;
    logic [CW-1:0]     pop_row;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                fbb_pkg::REG_BG_RED:      cfg_next.bg_red      = cfg_data[fbb_pkg::COLOR_W-1:0];
                fbb_pkg::REG_BG_GREEN:    cfg_next.bg_green    = cfg_data[fbb_pkg::COLOR_W-1:0];
                fbb_pkg::REG_BG_BLUE:     cfg_next.bg_blue     = cfg_data[fbb_pkg::COLOR_W-1:0];
                fbb_pkg::REG_IMAGE_WIDTH: cfg_next.image_width = cfg_data;
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bg_red      <= fbb_pkg::RST_BG_RED;
            cfg_reg.bg_green    <= fbb_pkg::RST_BG_GREEN;
            cfg_reg.bg_blue     <= fbb_pkg::RST_BG_BLUE;
            cfg_reg.image_width <= fbb_pkg::RST_IMAGE_WIDTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fbb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .full     (full),
        .push     (push),
        .push_tag (push_tag),
        .push_col (push_col),
        .push_row (push_row)
    );

    fbb_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_tag, push_col, push_row}),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    assign {pop_tag, pop_col, pop_row} = pop_data;

    fbb_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (!empty),
        .req_tag   (pop_tag),
        .req_col   (pop_col),
        .req_row   (pop_row),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    `FBB_ASSERT_IMPL(a_result_from_eof, $rose(out_valid), $past(pop && pop_tag.eof))
    `FBB_ASSERT_IMPL(a_empty_box_zero, out_valid && !out_data.found, out_data == '0)
    `FBB_ASSERT_NEXT(a_frame_restart, push && in_data.end_of_frame, {push_col, push_row} == '0)

endmodule

`default_nettype wire
